/* src/mss_pkg.sv */
// Shared types and constants for the sample-set median unit.
package mss_pkg;

   localparam int SAMPLE_W = 32;
   localparam int SIZE_W   = 6;

   typedef struct packed {
      logic                ins;
      logic                shl;
      logic [SAMPLE_W-1:0] sample;
   } cell_ctl_type;

endpackage

/* src/mss_cell.sv */
// One cell of the sorted insertion chain: holds one sample, shifts up on insert, down on drain.
module mss_cell
   import mss_pkg::*;
(
   input  logic                clock,
   input  cell_ctl_type        ctl,
   input  logic                occ,
   input  logic                tail,
   input  logic                prev_gt,
   input  logic [SAMPLE_W-1:0] prev_val,
   input  logic [SAMPLE_W-1:0] next_val,
   output logic                gt,
   output logic [SAMPLE_W-1:0] val
);

   logic [SAMPLE_W-1:0] val_ff;
   logic [SAMPLE_W-1:0] val_in;

   assign gt  = occ && (val_ff > ctl.sample);
   assign val = val_ff;

   always_comb begin
      val_in = val_ff;
      if (ctl.ins) begin
         if (gt || tail) begin
            val_in = prev_gt ? prev_val : ctl.sample;
         end
      end else if (ctl.shl) begin
         val_in = next_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

/* src/median_of_sample_set_unit.sv */
// Top level of the sample-set median unit: insertion chain of cells plus drain and result logic.
// A last beat starts the drain in ST_SHIFT; when the drain ends, the registered result strobe
// rises as busy falls. An empty set needs no drain step.
// Throughput: non-last beats one per cycle; a last beat keeps busy high until its result strobe.
// The drain walks the chain down to the middle, one cell position per cycle.
// Reset (synchronous): empties the set, clears overflow, returns to idle; cell data is not cleared.
module median_of_sample_set_unit
   import mss_pkg::*;
#(
   parameter int MAX_SAMPLES = 32
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_has_sample,
   input  logic                req_is_last,
   output logic                rsp_valid,
   output logic [SAMPLE_W-1:0] rsp_median,
   output logic [SIZE_W-1:0]   rsp_set_size,
   output logic                rsp_overflowed
);

   localparam int CW     = $clog2(MAX_SAMPLES + 1);
   localparam int SECOND = (MAX_SAMPLES > 1) ? 1 : 0;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SHIFT
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic                ovf_ff, ovf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_median_ff, rsp_median_in;
   logic [SIZE_W-1:0]   rsp_size_ff, rsp_size_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   cell_ctl_type        ctl;
   logic                accept;
   logic                full;
   logic                do_ins;
   logic [CW-1:0]       cnt_new;
   logic [SAMPLE_W:0]   pair_sum;

   logic [SAMPLE_W-1:0] cell_val [MAX_SAMPLES];
   logic                cell_gt  [MAX_SAMPLES];

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign full   = (cnt_ff == CW'(MAX_SAMPLES));
   assign do_ins = accept && req_has_sample && !full;

   assign ctl.ins    = do_ins;
   assign ctl.shl    = (state_ff == ST_SHIFT) && (rem_ff != '0);
   assign ctl.sample = req_sample;

   assign cnt_new  = cnt_ff + CW'(do_ins);
   assign pair_sum = {1'b0, cell_val[0]} + {1'b0, cell_val[SECOND]};

   for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_chain
      logic                prev_gt;
      logic [SAMPLE_W-1:0] prev_val;
      logic [SAMPLE_W-1:0] next_val;

      if (i == 0) begin : g_head
         assign prev_gt  = 1'b0;
         assign prev_val = '0;
      end else begin : g_body
         assign prev_gt  = cell_gt[i-1];
         assign prev_val = cell_val[i-1];
      end

      if (i == MAX_SAMPLES - 1) begin : g_end
         assign next_val = cell_val[i];
      end else begin : g_mid
         assign next_val = cell_val[i+1];
      end

      mss_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .occ      (cnt_ff > CW'(i)),
         .tail     (cnt_ff == CW'(i)),
         .prev_gt  (prev_gt),
         .prev_val (prev_val),
         .next_val (next_val),
         .gt       (cell_gt[i]),
         .val      (cell_val[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      ovf_in        = ovf_ff;
      rsp_valid_in  = 1'b0;
      rsp_median_in = rsp_median_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in = cnt_new;
               ovf_in = ovf_ff | (req_has_sample && full);
               if (req_is_last) begin
                  state_in = ST_SHIFT;
                  rem_in   = (cnt_new == '0) ? '0 : CW'((cnt_new - CW'(1)) >> 1);
               end
            end
         end
         ST_SHIFT: begin
            if (rem_ff != '0) begin
               rem_in = rem_ff - CW'(1);
            end else begin
               priority if (cnt_ff == '0) begin
                  rsp_median_in = '0;
               end else if (cnt_ff[0]) begin
                  rsp_median_in = cell_val[0];
               end else begin
                  rsp_median_in = pair_sum[SAMPLE_W:1];
               end
               rsp_valid_in = 1'b1;
               rsp_size_in  = SIZE_W'(cnt_ff);
               rsp_ovf_in   = ovf_ff;
               cnt_in       = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rem_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rem_ff       <= rem_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_median_ff <= rsp_median_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_median     = rsp_median_ff;
   assign rsp_set_size   = rsp_size_ff;
   assign rsp_overflowed = rsp_ovf_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_SAMPLES))
      else $error("set count above capacity");

   a_rsp_after_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE && cnt_ff == '0 && !ovf_ff))
      else $error("result beat without set cleared");

   a_drain_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && rem_ff != '0) |=>
         (state_ff == ST_SHIFT && rem_ff == $past(rem_ff) - CW'(1)))
      else $error("drain counter did not step");

   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && rem_ff == '0) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("drain end without result beat");

endmodule

/* tb/sv/tb_median_of_sample_set_unit.sv */
// Testbench for median_of_sample_set_unit: directed table, then random sets vs a predictor.
module tb_median_of_sample_set_unit;
   import mss_pkg::*;

   localparam int SET_CAP     = 32;
   localparam int CYCLE_LIMIT = 400000;
   localparam int BEAT_TARGET = 1570;

   typedef struct packed {
      logic [SAMPLE_W-1:0] median;
      logic [SIZE_W-1:0]   set_size;
      logic                overflowed;
   } median_result_type;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      bit                  has;
      bit                  last;
      int                  copies;
      bit                  has_want;
      median_result_type   want;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic                req_has_sample = 1'b0;
   logic                req_is_last = 1'b0;
   logic                rsp_valid;
   logic [SAMPLE_W-1:0] rsp_median;
   logic [SIZE_W-1:0]   rsp_set_size;
   logic                rsp_overflowed;

   bit                  beat_has_want = 1'b0;
   median_result_type   beat_want = '0;

   logic [SAMPLE_W-1:0] set_cells[$];
   bit                  set_dropped;
   median_result_type   pending_medians[$];

   int                  mismatches = 0;
   int                  beats_taken = 0;
   int                  medians_checked = 0;
   int                  overflow_sets = 0;
   int                  cycles = 0;

   median_of_sample_set_unit #(.MAX_SAMPLES(SET_CAP)) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_sample    (req_sample),
      .req_has_sample(req_has_sample),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_median    (rsp_median),
      .rsp_set_size  (rsp_set_size),
      .rsp_overflowed(rsp_overflowed)
   );

   always #2 clock = ~clock;

   // Sorted insertion; equal samples land after the ones already held.
   function automatic void add_to_set(logic [SAMPLE_W-1:0] v);
      int pos;
      if (set_cells.size() >= SET_CAP) begin
         set_dropped = 1'b1;
         return;
      end
      pos = set_cells.size();
      while (pos > 0 && set_cells[pos-1] > v)
         pos--;
      set_cells.insert(pos, v);
   endfunction

   function automatic median_result_type close_set();
      median_result_type r;
      int                n;
      logic [SAMPLE_W:0] sum;
      n = set_cells.size();
      if (n == 0)
         r.median = '0;
      else if (n % 2 == 1)
         r.median = set_cells[n/2];
      else begin
         sum = {1'b0, set_cells[n/2-1]} + {1'b0, set_cells[n/2]};
         r.median = sum[SAMPLE_W:1];
      end
      r.set_size   = SIZE_W'(n);
      r.overflowed = set_dropped;
      if (set_dropped)
         overflow_sets++;
      set_cells.delete();
      set_dropped = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      median_result_type exp_r;
      median_result_type got_r;
      if (!reset) begin
         if (start && !busy) begin
            beats_taken++;
            if (req_has_sample)
               add_to_set(req_sample);
            if (req_is_last) begin
               exp_r = close_set();
               pending_medians.push_back(beat_has_want ? beat_want : exp_r);
            end
         end
         if (rsp_valid) begin
            got_r = '{rsp_median, rsp_set_size, rsp_overflowed};
            if (pending_medians.size() == 0) begin
               $error("rsp_valid with no result pending");
               mismatches++;
            end else begin
               exp_r = pending_medians.pop_front();
               medians_checked++;
               if (got_r.median !== exp_r.median) begin
                  $error("median: expected %h, got %h", exp_r.median, got_r.median);
                  mismatches++;
               end
               if (got_r.set_size !== exp_r.set_size) begin
                  $error("set_size: expected %0d, got %0d", exp_r.set_size, got_r.set_size);
                  mismatches++;
               end
               if (got_r.overflowed !== exp_r.overflowed) begin
                  $error("overflowed: expected %b, got %b", exp_r.overflowed,
                         got_r.overflowed);
                  mismatches++;
               end
            end
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_beat(input logic [SAMPLE_W-1:0] s, input bit has, input bit last,
                            input int idle_pct, input bit has_want = 1'b0,
                            input median_result_type want = '0);
      while ($urandom_range(99) < idle_pct) begin
         start          <= 1'b0;
         req_sample     <= $urandom;
         req_has_sample <= $urandom_range(1);
         req_is_last    <= $urandom_range(1);
         @(negedge clock);
      end
      start          <= 1'b1;
      req_sample     <= s;
      req_has_sample <= has;
      req_is_last    <= last;
      beat_has_want  <= has_want;
      beat_want      <= want;
      while (busy)
         @(negedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      start <= 1'b0;
      while (pending_medians.size() != 0)
         @(negedge clock);
      repeat (24) @(negedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(int mode);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(7);
         2: return 32'hFFFF_FFFF - $urandom_range(15);
         default: return $urandom_range(3) == 0 ? 32'hFFFF_FFFF - $urandom_range(3)
                                               : $urandom_range(255);
      endcase
   endfunction

   stim_row_type plan[] = '{
      '{32'h0000_0000, 1'b0, 1'b1,  1, 1'b1, '{32'h0, 6'd0, 1'b0}},
      '{32'hDEAD_BEEF, 1'b0, 1'b0,  1, 1'b0, '0},
      '{32'hFFFF_FFFF, 1'b0, 1'b1,  1, 1'b1, '{32'h0, 6'd0, 1'b0}},
      '{32'hFFFF_FFFF, 1'b1, 1'b1,  1, 1'b1, '{32'hFFFF_FFFF, 6'd1, 1'b0}},
      '{32'hFFFF_FFFF, 1'b1, 1'b0,  1, 1'b0, '0},
      '{32'hFFFF_FFFF, 1'b1, 1'b1,  1, 1'b1, '{32'hFFFF_FFFF, 6'd2, 1'b0}},
      '{32'h0000_0000, 1'b1, 1'b0,  1, 1'b0, '0},
      '{32'hFFFF_FFFF, 1'b1, 1'b1,  1, 1'b1, '{32'h7FFF_FFFF, 6'd2, 1'b0}},
      '{32'd30,        1'b1, 1'b0,  1, 1'b0, '0},
      '{32'd10,        1'b1, 1'b0,  1, 1'b0, '0},
      '{32'd20,        1'b1, 1'b1,  1, 1'b0, '0},
      '{32'd5,         1'b1, 1'b0,  2, 1'b0, '0},
      '{32'd3,         1'b1, 1'b0,  1, 1'b0, '0},
      '{32'd5,         1'b1, 1'b0,  1, 1'b0, '0},
      '{32'd9,         1'b0, 1'b1,  1, 1'b0, '0},
      '{32'd5,         1'b1, 1'b0, 32, 1'b0, '0},
      '{32'd9,         1'b1, 1'b0,  1, 1'b0, '0},
      '{32'd0,         1'b1, 1'b1,  1, 1'b1, '{32'd5, 6'd32, 1'b1}},
      '{32'd1,         1'b1, 1'b1,  1, 1'b1, '{32'd1, 6'd1, 1'b0}},
      '{32'hAAAA_AAAA, 1'b1, 1'b0, 31, 1'b0, '0},
      '{32'h5555_5555, 1'b1, 1'b1,  1, 1'b0, '0}
   };

   initial begin
      int idle_pcts[4];
      int set_len;
      int mode;
      int random_beats;
      int phase_goal;
      bit last_has;
      int k;

      idle_pcts = '{0, 48, 0, 35};

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i])
         for (k = 0; k < plan[i].copies; k++)
            send_beat(plan[i].sample, plan[i].has,
                      plan[i].last && k == plan[i].copies - 1, 0,
                      plan[i].has_want && k == plan[i].copies - 1, plan[i].want);
      wait_drain();

      random_beats = 0;
      foreach (idle_pcts[p]) begin
         phase_goal = BEAT_TARGET * (p + 1) / 4;
         while (random_beats < phase_goal) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5, 6: set_len = $urandom_range(9);
               7, 8:                set_len = $urandom_range(32, 10);
               default:             set_len = $urandom_range(40, 33);
            endcase
            mode = $urandom_range(3);
            last_has = set_len > 0 && $urandom_range(1);
            for (k = 0; k < set_len - last_has; k++) begin
               if ($urandom_range(9) == 0) begin
                  send_beat($urandom, 1'b0, 1'b0, idle_pcts[p]);
                  random_beats++;
               end
               send_beat(pick_sample(mode), 1'b1, 1'b0, idle_pcts[p]);
               random_beats++;
            end
            send_beat(last_has ? pick_sample(mode) : $urandom, last_has, 1'b1, idle_pcts[p]);
            random_beats++;
         end
         wait_drain();
      end

      $display("Sent %0d beats (table plus random sets, four idle phases).",
               beats_taken);
      $display("Checked %0d medians, %0d of them from sets that overflowed.",
               medians_checked, overflow_sets);
      if (mismatches == 0 && pending_medians.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* median_of_sample_set_unit.f */
src/mss_pkg.sv
src/mss_cell.sv
src/median_of_sample_set_unit.sv
tb/sv/tb_median_of_sample_set_unit.sv
